@@ src/tked_pkg.sv @@
// shared types, codes and helper functions for the terminal key escape decoder
package tked_pkg;

    // event opcodes
    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_RESIZE = 2'd2;
    localparam logic [1:0] OP_EOF    = 2'd3;

    // key classes
    localparam logic [3:0] K_CHAR    = 4'd0;
    localparam logic [3:0] K_UP      = 4'd1;
    localparam logic [3:0] K_DOWN    = 4'd2;
    localparam logic [3:0] K_RIGHT   = 4'd3;
    localparam logic [3:0] K_LEFT    = 4'd4;
    localparam logic [3:0] K_HOME    = 4'd5;
    localparam logic [3:0] K_END     = 4'd6;
    localparam logic [3:0] K_DEL     = 4'd7;
    localparam logic [3:0] K_PGUP    = 4'd8;
    localparam logic [3:0] K_PGDN    = 4'd9;
    localparam logic [3:0] K_UNKNOWN = 4'd10;
    localparam logic [3:0] K_RESIZE  = 4'd11;
    localparam logic [3:0] K_EOF     = 4'd12;

    // character codes
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_CSI    = 8'h5B; // '['
    localparam logic [7:0] CH_SS3    = 8'h4F; // 'O'
    localparam logic [7:0] CH_LT     = 8'h3C; // '<'
    localparam logic [7:0] CH_UPPER_M = 8'h4D; // 'M'
    localparam logic [7:0] CH_LOWER_M = 8'h6D; // 'm'
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_3      = 8'h33;
    localparam logic [7:0] CH_4      = 8'h34;
    localparam logic [7:0] CH_5      = 8'h35;
    localparam logic [7:0] CH_6      = 8'h36;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_8      = 8'h38;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] FINAL_LO  = 8'h40;
    localparam logic [7:0] FINAL_HI  = 8'h7E;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam int X10_REPORT_BYTES_DEF   = 3;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_ESC1  = 7'b0000010,
        PH_ESC2  = 7'b0000100,
        PH_DIGIT = 7'b0001000,
        PH_SGR   = 7'b0010000,
        PH_X10   = 7'b0100000,
        PH_CSI   = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [1:0] event_opcode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0] key_class;
        logic [7:0] char_code;
    } t_out_item;

    function automatic logic is_final(input logic [7:0] b);
        return b inside {[FINAL_LO:FINAL_HI]};
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[CH_0:CH_9]};
    endfunction

    function automatic logic [3:0] digit_key(input logic [7:0] d);
        logic [3:0] k;
        case (d)
            CH_1:    k = K_HOME;
            CH_3:    k = K_DEL;
            CH_4:    k = K_END;
            CH_5:    k = K_PGUP;
            CH_6:    k = K_PGDN;
            CH_7:    k = K_HOME;
            CH_8:    k = K_END;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

@@ src/terminal_key_escape_decoder.sv @@
// top level of the terminal key escape decoder
//
// Decodes a stream of terminal input events (received byte, timer tick, resize,
// end of input) into keypresses. Plain bytes come out as characters; ESC opens a
// sequence which resolves to arrow, home, end, delete or page keys, to a lone ESC
// on timeout, resize or end of input, or to "unknown" for mouse reports and other
// CSI sequences, which are consumed up to their terminator. At most one key comes
// out per event. The block takes one event every clock cycle unless stalled: an
// event is held in an input register, the parser state and the key are worked out
// in combinational logic, and the key lands in an output register. The state
// update of the parser for each event is what sets this rate. While the output
// register holds a stalled key, the input register keeps any event it holds and
// the input side stalls. The escape timeout register
// is written through its own channel, which is always ready, and must only be
// written while no events are in flight. There is no clearing pass after reset.
module terminal_key_escape_decoder
    import tked_pkg::*;
#(
    parameter int X10_REPORT_BYTES = X10_REPORT_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // event channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    // key channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    // timeout register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    // x10 skip counter holds 0..X10_REPORT_BYTES
    localparam int SkipW = (X10_REPORT_BYTES < 2) ? 1 : $clog2(X10_REPORT_BYTES + 1);
    localparam logic [SkipW-1:0] SkipInit = SkipW'(X10_REPORT_BYTES);
    localparam logic [SkipW-1:0] SkipOne  = SkipW'(1);

    // configuration
    logic [15:0] r_timeout;

    // input register
    logic     r_in_valid;
    t_in_item r_in;

    // parser state
    t_phase           r_phase, n_phase;
    logic [7:0]       r_intro, n_intro;
    logic [7:0]       r_digit, n_digit;
    logic [SkipW-1:0] r_skip, n_skip;
    logic [15:0]      r_wait, n_wait;

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    // result of the current event
    logic      res_valid;
    t_out_item res;

    logic proc_go;   // event in the input register is consumed this cycle
    logic in_xfer;
    logic awaiting;  // waiting for one of the two bytes after ESC
    logic [15:0] wait_inc;
    logic [7:0]  b;

    // the event advances whenever the output register is free or drains now
    assign proc_go    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !proc_go;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign b        = r_in.rx_byte;
    assign awaiting = (r_phase == PH_ESC1) || (r_phase == PH_ESC2);
    // tick counter saturates at its top value
    assign wait_inc = (r_wait == 16'hFFFF) ? r_wait : r_wait + 16'd1;

    // parser next state and key
    always_comb begin
        n_phase   = r_phase;
        n_intro   = r_intro;
        n_digit   = r_digit;
        n_skip    = r_skip;
        n_wait    = r_wait;
        res_valid = 1'b0;
        res       = '{key_class: K_CHAR, char_code: 8'h00};

        case (r_in.event_opcode)
            OP_BYTE: begin
                case (r_phase)
                    PH_ESC1: begin
                        n_intro = b;
                        n_wait  = 16'd0;
                        n_phase = PH_ESC2;
                    end
                    PH_ESC2: begin
                        // second byte after ESC: result unless a longer form starts
                        n_phase       = PH_IDLE;
                        res_valid     = 1'b1;
                        res.key_class = K_UNKNOWN;
                        if (r_intro == CH_CSI) begin
                            case (b)
                                CH_LT: begin
                                    n_phase   = PH_SGR;
                                    res_valid = 1'b0;
                                end
                                CH_UPPER_M: begin
                                    n_skip    = SkipInit;
                                    n_phase   = PH_X10;
                                    res_valid = 1'b0;
                                end
                                CH_A:    res.key_class = K_UP;
                                CH_B:    res.key_class = K_DOWN;
                                CH_C:    res.key_class = K_RIGHT;
                                CH_D:    res.key_class = K_LEFT;
                                CH_H:    res.key_class = K_HOME;
                                CH_F:    res.key_class = K_END;
                                default: begin
                                    if (is_digit(b)) begin
                                        n_digit   = b;
                                        n_phase   = PH_DIGIT;
                                        res_valid = 1'b0;
                                    end else if (!is_final(b)) begin
                                        // parameter bytes: skip to a final byte
                                        n_phase   = PH_CSI;
                                        res_valid = 1'b0;
                                    end
                                end
                            endcase
                        end else if (r_intro == CH_SS3) begin
                            if (b == CH_H) begin
                                res.key_class = K_HOME;
                            end else if (b == CH_F) begin
                                res.key_class = K_END;
                            end
                        end
                    end
                    PH_DIGIT: begin
                        if (b == CH_TILDE) begin
                            n_phase       = PH_IDLE;
                            res_valid     = 1'b1;
                            res.key_class = digit_key(r_digit);
                        end else if (is_final(b)) begin
                            n_phase       = PH_IDLE;
                            res_valid     = 1'b1;
                            res.key_class = K_UNKNOWN;
                        end else begin
                            n_phase = PH_CSI;
                        end
                    end
                    PH_SGR: begin
                        if (b == CH_UPPER_M || b == CH_LOWER_M) begin
                            n_phase       = PH_IDLE;
                            res_valid     = 1'b1;
                            res.key_class = K_UNKNOWN;
                        end
                    end
                    PH_X10: begin
                        if (r_skip <= SkipOne) begin
                            n_skip        = '0;
                            n_phase       = PH_IDLE;
                            res_valid     = 1'b1;
                            res.key_class = K_UNKNOWN;
                        end else begin
                            n_skip = r_skip - SkipOne;
                        end
                    end
                    PH_CSI: begin
                        if (is_final(b)) begin
                            n_phase       = PH_IDLE;
                            res_valid     = 1'b1;
                            res.key_class = K_UNKNOWN;
                        end
                    end
                    default: begin
                        // idle, and any stray phase code
                        if (b == CH_ESC) begin
                            n_wait  = 16'd0;
                            n_phase = PH_ESC1;
                        end else begin
                            n_phase       = PH_IDLE;
                            res_valid     = 1'b1;
                            res.key_class = K_CHAR;
                            res.char_code = b;
                        end
                    end
                endcase
            end
            OP_TICK: begin
                // ticks only matter while waiting after ESC
                if (awaiting) begin
                    n_wait = wait_inc;
                    if (wait_inc >= r_timeout) begin
                        n_phase       = PH_IDLE;
                        res_valid     = 1'b1;
                        res.key_class = K_CHAR;
                        res.char_code = CH_ESC;
                    end
                end
            end
            default: begin
                // resize or end of input
                n_phase   = PH_IDLE;
                res_valid = 1'b1;
                case (r_phase)
                    PH_ESC1, PH_ESC2: begin
                        res.key_class = K_CHAR;
                        res.char_code = CH_ESC;
                    end
                    PH_DIGIT, PH_SGR, PH_X10, PH_CSI: begin
                        n_skip        = '0;
                        res.key_class = K_UNKNOWN;
                    end
                    default: begin
                        res.key_class = (r_in.event_opcode == OP_RESIZE) ? K_RESIZE : K_EOF;
                    end
                endcase
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_intro     <= 8'h00;
            r_digit     <= 8'h00;
            r_skip      <= '0;
            r_wait      <= 16'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end

            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (proc_go) begin
                r_in_valid <= 1'b0;
            end

            if (proc_go) begin
                r_phase <= n_phase;
                r_intro <= n_intro;
                r_digit <= n_digit;
                r_skip  <= n_skip;
                r_wait  <= n_wait;
            end

            if (proc_go && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
        if (proc_go && res_valid) begin
            r_out <= res;
        end
    end

    // resize or end of input always ends any sequence
    a_nonbyte_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_go && (r_in.event_opcode == OP_RESIZE || r_in.event_opcode == OP_EOF))
        |=> (r_phase == PH_IDLE))
        else $error("parser not idle after resize or end of input");

    // resize or end of input always yields a key
    a_nonbyte_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_go && (r_in.event_opcode == OP_RESIZE || r_in.event_opcode == OP_EOF))
        |=> o_out_valid)
        else $error("no key for resize or end of input");

    // a plain byte when idle comes straight out as a character
    a_plain_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_go && r_phase == PH_IDLE && r_in.event_opcode == OP_BYTE &&
         r_in.rx_byte != CH_ESC)
        |=> (o_out_valid && o_out_data.key_class == K_CHAR &&
             o_out_data.char_code == $past(r_in.rx_byte)))
        else $error("plain byte not passed through");

    // x10 skip count never exceeds the report length
    a_skip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip <= SkipInit)
        else $error("x10 skip count out of range");

endmodule

@@ tb/terminal_key_escape_decoder_tb.sv @@
// self-checking testbench for the terminal key escape decoder
module terminal_key_escape_decoder_tb
    import tked_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 11;
    // keys land after their event passes the input and output registers; settle before touching the register
    localparam int SETTLE_CYCLES = 6;
    // watchdog limit for the whole run, heavy stalls included
    localparam int CYCLE_LIMIT   = 50_000;
    localparam int X10_BYTES     = X10_REPORT_BYTES_DEF;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data  = '0;

    // stimulus and scoreboard
    t_in_item  pending_events[$];
    t_out_item expected_keys[$];
    int        queued_count;
    int        gen_timeout;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    logic      ev_taken       = 1'b0;
    logic      cfg_taken      = 1'b0;

    // run statistics
    int cycle_count  = 0;
    int error_count  = 0;
    int events_taken = 0;
    int keys_checked = 0;
    int cfg_writes   = 0;

    // decoder state as the testbench sees it
    t_phase      dec_phase    = PH_IDLE;
    logic [7:0]  intro_seen   = '0;
    logic [7:0]  digit_seen   = '0;
    logic [1:0]  x10_left     = '0;
    logic [15:0] tick_count   = '0;
    logic [15:0] timeout_copy = TIMEOUT_RESET;

    terminal_key_escape_decoder #(
        .X10_REPORT_BYTES(X10_BYTES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // watchdog: a hung handshake or a missing key ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d keys outstanding", cycle_count,
                     expected_keys.size());
            $display("tb: failure");
            $finish;
        end
    end

    // one line per mismatch
    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // works out the key, if any, that one event produces and advances the parser copy
    task automatic decode_event(input t_in_item ev, output bit has_key, output t_out_item key);
        logic [7:0] b;
        logic [3:0] cls;
        logic [7:0] ch;
        bit         awaiting;
        bit         is_term;
        bit         done;
        b        = ev.rx_byte;
        awaiting = (dec_phase == PH_ESC1) || (dec_phase == PH_ESC2);
        is_term  = (b >= FINAL_LO) && (b <= FINAL_HI);
        done     = 1'b0;
        cls      = K_UNKNOWN;
        ch       = '0;
        case (ev.event_opcode)
            OP_BYTE: begin
                case (dec_phase)
                    PH_ESC1: begin
                        // first byte after escape restarts the wait for the second
                        intro_seen = b;
                        tick_count = '0;
                        dec_phase  = PH_ESC2;
                    end
                    PH_ESC2: begin
                        if (intro_seen == CH_CSI) begin
                            case (b)
                                CH_LT: dec_phase = PH_SGR;
                                CH_UPPER_M: begin
                                    x10_left  = 2'(X10_BYTES);
                                    dec_phase = PH_X10;
                                end
                                CH_A: begin done = 1'b1; cls = K_UP;    end
                                CH_B: begin done = 1'b1; cls = K_DOWN;  end
                                CH_C: begin done = 1'b1; cls = K_RIGHT; end
                                CH_D: begin done = 1'b1; cls = K_LEFT;  end
                                CH_H: begin done = 1'b1; cls = K_HOME;  end
                                CH_F: begin done = 1'b1; cls = K_END;   end
                                default: begin
                                    if (b >= CH_0 && b <= CH_9) begin
                                        digit_seen = b;
                                        dec_phase  = PH_DIGIT;
                                    end else if (is_term) begin
                                        done = 1'b1;
                                    end else begin
                                        dec_phase = PH_CSI;
                                    end
                                end
                            endcase
                        end else if (intro_seen == CH_SS3 && b == CH_H) begin
                            done = 1'b1;
                            cls  = K_HOME;
                        end else if (intro_seen == CH_SS3 && b == CH_F) begin
                            done = 1'b1;
                            cls  = K_END;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    PH_DIGIT: begin
                        if (b == CH_TILDE) begin
                            done = 1'b1;
                            case (digit_seen)
                                CH_1, CH_7: cls = K_HOME;
                                CH_3:       cls = K_DEL;
                                CH_4, CH_8: cls = K_END;
                                CH_5:       cls = K_PGUP;
                                CH_6:       cls = K_PGDN;
                                default:    cls = K_UNKNOWN;
                            endcase
                        end else if (is_term) begin
                            done = 1'b1;
                        end else begin
                            dec_phase = PH_CSI;
                        end
                    end
                    PH_SGR: begin
                        if (b == CH_UPPER_M || b == CH_LOWER_M)
                            done = 1'b1;
                    end
                    PH_X10: begin
                        if (x10_left <= 2'd1) begin
                            x10_left = '0;
                            done     = 1'b1;
                        end else begin
                            x10_left = x10_left - 2'd1;
                        end
                    end
                    PH_CSI: begin
                        if (is_term)
                            done = 1'b1;
                    end
                    default: begin
                        if (b == CH_ESC) begin
                            tick_count = '0;
                            dec_phase  = PH_ESC1;
                        end else begin
                            done = 1'b1;
                            cls  = K_CHAR;
                            ch   = b;
                        end
                    end
                endcase
            end
            OP_TICK: begin
                // ticks only matter while waiting on the bytes after escape
                if (awaiting) begin
                    if (tick_count != 16'hFFFF)
                        tick_count = tick_count + 16'd1;
                    if (tick_count >= timeout_copy) begin
                        done = 1'b1;
                        cls  = K_CHAR;
                        ch   = CH_ESC;
                    end
                end
            end
            default: begin
                // resize or end of input: reported when idle, otherwise it closes the sequence
                done = 1'b1;
                if (dec_phase == PH_IDLE) begin
                    cls = (ev.event_opcode == OP_RESIZE) ? K_RESIZE : K_EOF;
                end else if (awaiting) begin
                    cls = K_CHAR;
                    ch  = CH_ESC;
                end else begin
                    x10_left = '0;
                end
            end
        endcase
        has_key = done;
        key     = '0;
        if (done) begin
            key.key_class = cls;
            key.char_code = ch;
            dec_phase     = PH_IDLE;
        end
    endtask

    // monitor: checks key transfers, predicts from event transfers, tracks register writes
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item new_key;
        bit        makes_key;
        if (!i_rst_n) begin
            ev_taken     <= 1'b0;
            cfg_taken    <= 1'b0;
            dec_phase    = PH_IDLE;
            intro_seen   = '0;
            digit_seen   = '0;
            x10_left     = '0;
            tick_count   = '0;
            timeout_copy = TIMEOUT_RESET;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                keys_checked++;
                if (expected_keys.size() == 0) begin
                    report_mismatch($sformatf("key class %0d char %02h with none expected",
                                              o_out_data.key_class, o_out_data.char_code));
                end else begin
                    want = expected_keys.pop_front();
                    if (o_out_data.key_class !== want.key_class)
                        report_mismatch($sformatf("key class %0d, expected %0d",
                                                  o_out_data.key_class, want.key_class));
                    if (o_out_data.char_code !== want.char_code)
                        report_mismatch($sformatf("char code %02h, expected %02h",
                                                  o_out_data.char_code, want.char_code));
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                timeout_copy = i_cfg_data;
            if (i_in_valid && !o_in_stall) begin
                events_taken++;
                decode_event(i_in_data, makes_key, new_key);
                if (makes_key)
                    expected_keys.push_back(new_key);
            end
            ev_taken  <= i_in_valid && !o_in_stall;
            cfg_taken <= i_cfg_valid && o_cfg_ready;
        end
    end

    // driver: presents queued events and randomises the key-side stall at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            // a held event only moves on once it has been transferred
            if (!i_in_valid || ev_taken) begin
                if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_events.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    function automatic void push_byte(input logic [7:0] b);
        t_in_item ev;
        ev.event_opcode = OP_BYTE;
        ev.rx_byte      = b;
        pending_events.push_back(ev);
        queued_count++;
    endfunction

    // non-byte events carry a random, unused byte
    function automatic void push_signal(input logic [1:0] op, input bit counts);
        t_in_item ev;
        ev.event_opcode = op;
        ev.rx_byte      = 8'($urandom_range(0, 255));
        pending_events.push_back(ev);
        if (counts)
            queued_count++;
    endfunction

    function automatic void push_ticks(input int n);
        repeat (n) push_signal(OP_TICK, 1'b1);
    endfunction

    // sometimes up to four ticks, fewer than the timeout, between the bytes of a sequence
    function automatic void gap_ticks();
        int most;
        most = (gen_timeout - 1 > 4) ? 4 : gen_timeout - 1;
        if (most >= 1 && $urandom_range(0, 3) == 0)
            push_ticks($urandom_range(1, most));
    endfunction

    function automatic logic [7:0] term_byte();
        return 8'($urandom_range(FINAL_LO, FINAL_HI));
    endfunction

    function automatic logic [7:0] nonterm_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b >= FINAL_LO && b <= FINAL_HI);
        return b;
    endfunction

    function automatic logic [7:0] csi_digit();
        return 8'($urandom_range(CH_0, CH_9));
    endfunction

    function automatic void open_csi();
        push_byte(CH_ESC);
        gap_ticks();
        push_byte(CH_CSI);
        gap_ticks();
    endfunction

    // one random sequence, well formed most of the time
    task automatic queue_sequence();
        int         pick;
        int         n;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_ESC);
            push_byte(b);
        end else if (pick < 30) begin
            // cursor keys and home/end in CSI form
            open_csi();
            case ($urandom_range(0, 5))
                0:       push_byte(CH_A);
                1:       push_byte(CH_B);
                2:       push_byte(CH_C);
                3:       push_byte(CH_D);
                4:       push_byte(CH_H);
                default: push_byte(CH_F);
            endcase
        end else if (pick < 38) begin
            // SS3 form, sometimes with a byte it does not know
            push_byte(CH_ESC);
            gap_ticks();
            push_byte(CH_SS3);
            gap_ticks();
            case ($urandom_range(0, 2))
                0:       push_byte(CH_H);
                1:       push_byte(CH_F);
                default: push_byte(8'($urandom_range(0, 255)));
            endcase
        end else if (pick < 50) begin
            // digit forms: tilde, another terminator, or a longer parameter run
            open_csi();
            push_byte(csi_digit());
            n = $urandom_range(0, 9);
            if (n < 7) begin
                push_byte(CH_TILDE);
            end else if (n < 8) begin
                push_byte(term_byte());
            end else begin
                push_byte(nonterm_byte());
                push_byte(term_byte());
            end
        end else if (pick < 58) begin
            // SGR mouse report, ticks inside are ignored
            open_csi();
            push_byte(CH_LT);
            n = $urandom_range(0, 6);
            repeat (n) begin
                if ($urandom_range(0, 7) == 0)
                    push_signal(OP_TICK, 1'b1);
                push_byte($urandom_range(0, 3) == 0 ? 8'h3B : csi_digit());
            end
            push_byte($urandom_range(0, 1) ? CH_UPPER_M : CH_LOWER_M);
        end else if (pick < 64) begin
            // X10 mouse report: three raw bytes follow
            open_csi();
            push_byte(CH_UPPER_M);
            repeat (X10_BYTES) push_byte(8'($urandom_range(0, 255)));
        end else if (pick < 72) begin
            open_csi();
            if ($urandom_range(0, 1)) begin
                do b = term_byte();
                while (b inside {CH_A, CH_B, CH_C, CH_D, CH_F, CH_H, CH_UPPER_M});
                push_byte(b);
            end else begin
                do b = nonterm_byte(); while ((b >= CH_0 && b <= CH_9) || b == CH_LT);
                push_byte(b);
                n = $urandom_range(0, 3);
                repeat (n) push_byte(nonterm_byte());
                push_byte(term_byte());
            end
        end else if (pick < 76) begin
            // introducer other than CSI, then a random byte
            push_byte(CH_ESC);
            do b = 8'($urandom_range(0, 255)); while (b == CH_CSI);
            push_byte(b);
            push_byte(8'($urandom_range(0, 255)));
        end else if (pick < 82) begin
            // lone escape cut short by resize or end of input
            push_byte(CH_ESC);
            gap_ticks();
            if ($urandom_range(0, 1))
                push_byte(8'($urandom_range(0, 255)));
            push_signal($urandom_range(0, 1) ? OP_RESIZE : OP_EOF, 1'b1);
        end else if (pick < 88) begin
            // sequence broken mid-way while skipping or after a digit
            open_csi();
            case ($urandom_range(0, 3))
                0: begin
                    push_byte(CH_LT);
                    repeat ($urandom_range(0, 2)) push_byte(csi_digit());
                end
                1: push_byte(csi_digit());
                2: begin
                    push_byte(CH_UPPER_M);
                    repeat ($urandom_range(0, X10_BYTES - 1))
                        push_byte(8'($urandom_range(0, 255)));
                end
                default: push_byte(8'h20);
            endcase
            push_signal($urandom_range(0, 1) ? OP_RESIZE : OP_EOF, 1'b1);
        end else if (pick < 92 && gen_timeout <= 128) begin
            // lone escape by timeout, before or after the first byte
            push_byte(CH_ESC);
            if ($urandom_range(0, 1))
                push_byte(8'($urandom_range(0, 255)));
            push_ticks(gen_timeout == 0 ? 1 : gen_timeout);
        end else if (pick < 96) begin
            case ($urandom_range(0, 2))
                0:       push_signal(OP_RESIZE, 1'b1);
                1:       push_signal(OP_EOF, 1'b1);
                default: push_signal(OP_TICK, 1'b0);
            endcase
        end else begin
            // noise
            n = $urandom_range(1, 3);
            repeat (n) begin
                if ($urandom_range(0, 1))
                    push_byte(8'($urandom_range(0, 255)));
                else
                    push_signal(2'($urandom_range(0, 3)), 1'b1);
            end
        end
    endtask

    task automatic queue_directed();
        push_byte(8'h00);
        push_byte(8'hFF);
        push_signal(OP_TICK, 1'b0);
        push_signal(OP_RESIZE, 1'b1);
        push_signal(OP_EOF, 1'b1);
        // up arrow, SS3 home, delete
        push_byte(CH_ESC); push_byte(CH_CSI); push_byte(CH_A);
        push_byte(CH_ESC); push_byte(CH_SS3); push_byte(CH_H);
        push_byte(CH_ESC); push_byte(CH_CSI); push_byte(CH_3); push_byte(CH_TILDE);
        // lone escape on resize, SGR report cut by end of input
        push_byte(CH_ESC); push_signal(OP_RESIZE, 1'b1);
        push_byte(CH_ESC); push_byte(CH_CSI); push_byte(CH_LT); push_signal(OP_EOF, 1'b1);
        // digit with an unmapped tilde form
        push_byte(CH_ESC); push_byte(CH_CSI); push_byte(CH_9); push_byte(CH_TILDE);
    endtask

    // waits until every event is in and every key is out, then lets the pipeline settle
    task automatic drain_and_settle();
        while (pending_events.size() != 0 || i_in_valid || expected_keys.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_batch(input int target);
        queued_count = 0;
        while (queued_count < target)
            queue_sequence();
        drain_and_settle();
    endtask

    task automatic set_timeout(input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
        gen_timeout = value;
        cfg_writes++;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender mostly busy, receiver stalling heavily; reset value of the timeout first
        set_idling(21, 73);
        gen_timeout = TIMEOUT_RESET;
        queue_directed();
        run_batch(110);
        set_timeout(16'd1);
        run_batch(130);

        // the other way round, including a zero timeout
        set_idling(73, 21);
        set_timeout(16'd0);
        run_batch(130);
        set_timeout(16'd2);
        run_batch(130);

        // no idling: a wait just short of the timeout, then one that times out
        set_idling(0, 0);
        set_timeout(16'd30);
        push_byte(CH_ESC);
        push_ticks(29);
        push_byte(CH_CSI);
        push_ticks(30);
        run_batch(100);
        set_timeout(16'($urandom_range(3, 40)));
        run_batch(130);

        $display("covered %0d event transfers and %0d key transfers over %0d timeout writes",
                 events_taken, keys_checked, cfg_writes);
        $display("idling went sender-light/receiver-heavy, the reverse, then none");
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", error_count);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
